FILE: hw/rtl/wtwm_pkg.sv
// ----------------------------------------------------------------------------
// wtwm_pkg
// Shared types, constants and helpers for the weekly time window matcher.
// ----------------------------------------------------------------------------
package wtwm_pkg;

   localparam int unsigned MIN_PER_HOUR = 60;
   localparam int unsigned HOUR_PER_DAY = 24;
   localparam int unsigned DAY_MINUTES  = HOUR_PER_DAY * MIN_PER_HOUR;
   localparam int unsigned WEEK_DAYS    = 7;
   localparam logic [7:0]  WDAY_ALL     = 8'h7F;
   localparam int unsigned TIME_W       = 13;   // signed, holds -1440..2879

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_CHECK = 1'b1;

   typedef logic signed [TIME_W-1:0] time_type;

   // stored schedule entry, same layout as the load word
   typedef struct packed {
      logic [6:0] day_mask;
      logic [5:0] end_min;
      logic [4:0] end_hour;
      logic [5:0] start_min;
      logic [4:0] start_hour;
   } entry_type;

   typedef struct packed {
      logic        kind;
      logic [3:0]  range_first;
      logic [3:0]  range_end;
      logic [28:0] entry_word;
      logic [4:0]  now_hour;
      logic [5:0]  now_minute;
      logic [7:0]  weekday;
      logic        cmd_on;
      logic        cmd_enable;
      logic [4:0]  cmd_hour;
      logic [5:0]  cmd_minute;
   } req_item_type;

   typedef struct packed {
      logic       switch_on;
      logic       cmd_enable_next;
      logic       window_matched;
      logic [2:0] matched_index;
   } rsp_item_type;

   // controller -> datapath
   typedef struct packed {
      logic start_load;
      logic start_check;
      logic advance;
      logic capture;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic live;   // scan pointer still inside range and table
      logic hit;    // entry under the pointer matches
   } dp_status_type;

   function automatic time_type hm_to_min(input logic [4:0] hour, input logic [5:0] minute);
      logic [TIME_W-1:0] t;
      t = TIME_W'(hour) * TIME_W'(MIN_PER_HOUR) + TIME_W'(minute);
      return $signed(t);
   endfunction

   // mod 7 by folding octal digits (8 == 1 mod 7)
   function automatic logic [2:0] mod7(input logic [7:0] v);
      logic [4:0] s1;
      logic [3:0] s2;
      s1 = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[7:6]);
      s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
      return (s2 >= 4'(WEEK_DAYS)) ? 3'(s2 - 4'(WEEK_DAYS)) : s2[2:0];
   endfunction

   function automatic logic [4:0] hour_wrap(input logic [4:0] h);
      return (h >= 5'(HOUR_PER_DAY)) ? 5'(h - 5'(HOUR_PER_DAY)) : h;
   endfunction

   function automatic logic [5:0] min_wrap(input logic [5:0] m);
      return (m >= 6'(MIN_PER_HOUR)) ? 6'(m - 6'(MIN_PER_HOUR)) : m;
   endfunction

endpackage

FILE: hw/rtl/wtwm_req_if.sv
// ----------------------------------------------------------------------------
// wtwm_req_if
// Request channel: load or check items, valid/ready handshake.
// ----------------------------------------------------------------------------
interface wtwm_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [3:0]  range_first;
   logic [3:0]  range_end;
   logic [28:0] entry_word;
   logic [4:0]  now_hour;
   logic [5:0]  now_minute;
   logic [7:0]  weekday;
   logic        cmd_on;
   logic        cmd_enable;
   logic [4:0]  cmd_hour;
   logic [5:0]  cmd_minute;

   modport source (
      output valid, kind, range_first, range_end, entry_word, now_hour, now_minute,
             weekday, cmd_on, cmd_enable, cmd_hour, cmd_minute,
      input  ready
   );
   modport sink (
      input  valid, kind, range_first, range_end, entry_word, now_hour, now_minute,
             weekday, cmd_on, cmd_enable, cmd_hour, cmd_minute,
      output ready
   );
endinterface

FILE: hw/rtl/wtwm_rsp_if.sv
// ----------------------------------------------------------------------------
// wtwm_rsp_if
// Response channel: one item per check, valid/ready handshake.
// ----------------------------------------------------------------------------
interface wtwm_rsp_if;
   logic       valid;
   logic       ready;
   logic       switch_on;
   logic       cmd_enable_next;
   logic       window_matched;
   logic [2:0] matched_index;

   modport source (
      output valid, switch_on, cmd_enable_next, window_matched, matched_index,
      input  ready
   );
   modport sink (
      input  valid, switch_on, cmd_enable_next, window_matched, matched_index,
      output ready
   );
endinterface

FILE: hw/rtl/wtwm_ctrl.sv
// ----------------------------------------------------------------------------
// wtwm_ctrl
// Handshake and scan sequencer; owns the response valid flag.
// ----------------------------------------------------------------------------
module wtwm_ctrl
   import wtwm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_kind,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_fire;
   logic slot_free;
   logic finish;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign finish    = status.hit | ~status.live;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in         = state_ff;
      cmd.start_load   = 1'b0;
      cmd.start_check  = 1'b0;
      cmd.advance      = 1'b0;
      cmd.capture      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_kind == KIND_LOAD) begin
                  cmd.start_load = 1'b1;
               end else begin
                  cmd.start_check = 1'b1;
                  state_in        = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (finish) begin
               // hold the pointer until the output slot frees up
               if (slot_free) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else begin
               cmd.advance = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.capture | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hw/rtl/wtwm_dpath.sv
// ----------------------------------------------------------------------------
// wtwm_dpath
// Schedule table, scan pointer, window test and result register.
// ----------------------------------------------------------------------------
module wtwm_dpath
   import wtwm_pkg::*;
#(
   parameter int unsigned ENTRIES = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  ctl_cmd_type   cmd,
   input  req_item_type  req,
   output dp_status_type status,
   output rsp_item_type  rsp
);

   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [5:0]  ENT_C = 6'(ENTRIES);

   // table: entries not yet written read as zero
   entry_type          tbl_ff [ENTRIES];
   logic [ENTRIES-1:0] tbl_vld_ff;
   entry_type          wr_entry_in;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_idx;

   // per-check context
   logic [3:0]   scan_ff, scan_in;
   logic [3:0]   last_ff, last_in;
   time_type     now_ff, now_in;
   time_type     cmdt_ff, cmdt_in;
   logic [2:0]   pos0_ff, pos0_in;
   logic [2:0]   pos5_ff, pos5_in;
   logic [2:0]   pos6_ff, pos6_in;
   logic         con_ff, con_in;
   logic         cen_ff, cen_in;
   rsp_item_type rsp_ff, rsp_in;

   logic [7:0]       wday;
   logic [IDX_W-1:0] rd_idx;
   entry_type        cur;
   time_type         st, en, st_a, en_a;
   logic [2:0]       pos;
   logic             in_win, cmd_in_win;

   // ---- load path ----
   assign wr_en  = cmd.start_load & ({2'b00, req.range_first} < ENT_C);
   assign wr_idx = IDX_W'(req.range_first);

   always_comb begin
      wr_entry_in.start_hour = hour_wrap(req.entry_word[4:0]);
      wr_entry_in.start_min  = min_wrap(req.entry_word[10:5]);
      wr_entry_in.end_hour   = hour_wrap(req.entry_word[15:11]);
      wr_entry_in.end_min    = min_wrap(req.entry_word[21:16]);
      wr_entry_in.day_mask   = req.entry_word[28:22];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_ff[wr_idx] <= wr_entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_vld_ff <= '0;
      end else if (wr_en) begin
         tbl_vld_ff[wr_idx] <= 1'b1;
      end
   end

   // ---- check context ----
   assign wday = ((req.weekday == 8'd0) || (req.weekday > WDAY_ALL)) ? WDAY_ALL : req.weekday;

   always_comb begin
      scan_in = scan_ff;
      last_in = last_ff;
      now_in  = now_ff;
      cmdt_in = cmdt_ff;
      pos0_in = pos0_ff;
      pos5_in = pos5_ff;
      pos6_in = pos6_ff;
      con_in  = con_ff;
      cen_in  = cen_ff;
      if (cmd.start_check) begin
         scan_in = req.range_first;
         last_in = req.range_end;
         now_in  = hm_to_min(req.now_hour, req.now_minute);
         cmdt_in = hm_to_min(req.cmd_hour, req.cmd_minute);
         pos0_in = mod7(wday);
         pos5_in = mod7(8'(wday + 8'd5));
         pos6_in = mod7(8'(wday + 8'd6));
         con_in  = req.cmd_on;
         cen_in  = req.cmd_enable;
      end else if (cmd.advance) begin
         scan_in = 4'(scan_ff + 4'd1);
      end
   end

   // ---- window test on the entry under the pointer ----
   assign status.live = (scan_ff < last_ff) && ({2'b00, scan_ff} < ENT_C);
   assign rd_idx      = IDX_W'(scan_ff);

   always_comb begin
      cur = status.live && tbl_vld_ff[rd_idx] ? tbl_ff[rd_idx] : '0;
      st  = hm_to_min(cur.start_hour, cur.start_min);
      en  = hm_to_min(cur.end_hour, cur.end_min);
      st_a = st;
      en_a = en;
      pos  = pos0_ff;
      if (en < st) begin
         if (now_ff < en) begin
            st_a = st - TIME_W'(DAY_MINUTES);
            pos  = pos5_ff;
         end else begin
            en_a = en + TIME_W'(DAY_MINUTES);
            pos  = pos6_ff;
         end
      end
      in_win     = (st_a <= now_ff) && (now_ff < en_a);
      cmd_in_win = (st_a <= cmdt_ff) && (cmdt_ff < en_a);
   end

   assign status.hit = status.live & cur.day_mask[pos] & in_win;

   // ---- result and remote override ----
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.capture) begin
         if (status.hit) begin
            rsp_in.switch_on       = ~(~con_ff & cen_ff & cmd_in_win);
            rsp_in.cmd_enable_next = ~con_ff & cen_ff;
            rsp_in.window_matched  = 1'b1;
            rsp_in.matched_index   = scan_ff[2:0];
         end else begin
            rsp_in.switch_on       = con_ff & cen_ff;
            rsp_in.cmd_enable_next = con_ff & cen_ff;
            rsp_in.window_matched  = 1'b0;
            rsp_in.matched_index   = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      last_ff <= last_in;
      now_ff  <= now_in;
      cmdt_ff <= cmdt_in;
      pos0_ff <= pos0_in;
      pos5_ff <= pos5_in;
      pos6_ff <= pos6_in;
      con_ff  <= con_in;
      cen_ff  <= cen_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp = rsp_ff;

endmodule

FILE: hw/rtl/weekly_time_window_matcher.sv
// Loads: a load is written at its accept edge and visible on the next cycle.
// A check scans its range one entry per cycle until the first hit or the end of the range
// or table, then waits for the output register to be free before registering its result.
// Throughput: one load per cycle while no check is in progress; no new item is taken
// until a check has captured its result, as the single window comparator does the scan.
// Reset (synchronous, active high) empties the table and drops any pending result.
// ----------------------------------------------------------------------------
// weekly_time_window_matcher
// Weekly programmable time switch: schedule table plus remote override.
// ----------------------------------------------------------------------------
module weekly_time_window_matcher
   import wtwm_pkg::*;
#(
   parameter int unsigned ENTRIES = 8   // schedule table depth, 1..8 (3-bit matched_index)
) (
   input logic        clock,
   input logic        reset,
   wtwm_req_if.sink   req_ch,
   wtwm_rsp_if.source rsp_ch
);

   ctl_cmd_type   cmd;
   dp_status_type status;
   req_item_type  req_item;
   rsp_item_type  rsp_item;

   // gather request payload into one bundle for the datapath
   always_comb begin
      req_item.kind        = req_ch.kind;
      req_item.range_first = req_ch.range_first;
      req_item.range_end   = req_ch.range_end;
      req_item.entry_word  = req_ch.entry_word;
      req_item.now_hour    = req_ch.now_hour;
      req_item.now_minute  = req_ch.now_minute;
      req_item.weekday     = req_ch.weekday;
      req_item.cmd_on      = req_ch.cmd_on;
      req_item.cmd_enable  = req_ch.cmd_enable;
      req_item.cmd_hour    = req_ch.cmd_hour;
      req_item.cmd_minute  = req_ch.cmd_minute;
   end

   // sequencer: idle accepts items; scan steps the pointer until a hit or
   // the range runs out, then parks until the output register is free
   wtwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.kind),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // table, window comparator and result register
   wtwm_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .req    (req_item),
      .status (status),
      .rsp    (rsp_item)
   );

   assign rsp_ch.switch_on       = rsp_item.switch_on;
   assign rsp_ch.cmd_enable_next = rsp_item.cmd_enable_next;
   assign rsp_ch.window_matched  = rsp_item.window_matched;
   assign rsp_ch.matched_index   = rsp_item.matched_index;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives load and check items into the weekly time window matcher. A local
// schedule table predicts every check result, and each result is compared
// field by field. Both channels stall at random.
// ----------------------------------------------------------------------------
module testbench
   import wtwm_pkg::*;
();

   localparam int ENTRY_COUNT    = 8;
   localparam int CLK_HALF       = 5;
   localparam int CLK_PERIOD     = 2 * CLK_HALF;
   localparam int RESET_CYCLES   = 10;
   localparam int MAX_WAIT       = 11;
   localparam int SETTLE_CYCLES  = 2 * ENTRY_COUNT + 4;   // longest check plus margin
   localparam int RANDOM_ITEMS   = 550;
   localparam int TIMEOUT_CYCLES = 200_000;

   logic clock = 1'b0;
   logic reset;

   wtwm_req_if req_ch ();
   wtwm_rsp_if rsp_ch ();

   weekly_time_window_matcher #(
      .ENTRIES (ENTRY_COUNT)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // local copy of the schedule table, updated at each accepted in-range load;
   // starts cleared like the table after reset
   entry_type    sched_model [ENTRY_COUNT] = '{default: '0};
   // switch verdicts predicted for accepted checks, oldest first
   rsp_item_type pending_verdicts [$];
   int           fault_count = 0;
   // when set, neither side inserts idle cycles
   bit           idle_off = 1'b0;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Folds one accepted item into the local table, or predicts its verdict.
   function automatic void predict_switch(input req_item_type it);
      entry_type    e;
      rsp_item_type r;
      int           now_t, cmd_t, st, en, wd, pos, i;
      bit           hit, on, c_en;

      if (it.kind == KIND_LOAD) begin
         // out-of-range index: load dropped
         if (it.range_first < ENTRY_COUNT) begin
            e.start_hour = 5'(it.entry_word[4:0]   % HOUR_PER_DAY);
            e.start_min  = 6'(it.entry_word[10:5]  % MIN_PER_HOUR);
            e.end_hour   = 5'(it.entry_word[15:11] % HOUR_PER_DAY);
            e.end_min    = 6'(it.entry_word[21:16] % MIN_PER_HOUR);
            e.day_mask   = it.entry_word[28:22];
            sched_model[it.range_first] = e;
         end
         return;
      end

      // check times are taken raw, no reduction
      now_t = int'(it.now_hour) * int'(MIN_PER_HOUR) + int'(it.now_minute);
      cmd_t = int'(it.cmd_hour) * int'(MIN_PER_HOUR) + int'(it.cmd_minute);
      wd    = int'(it.weekday);
      if (wd < 1 || wd > int'(WDAY_ALL)) begin
         wd = int'(WDAY_ALL);
      end
      c_en = it.cmd_enable;
      hit  = 1'b0;
      on   = 1'b0;
      r    = '0;

      for (i = int'(it.range_first);
           i < int'(it.range_end) && i < ENTRY_COUNT && !hit; i++) begin
         e  = sched_model[i];
         st = int'(e.start_hour) * int'(MIN_PER_HOUR) + int'(e.start_min);
         en = int'(e.end_hour) * int'(MIN_PER_HOUR) + int'(e.end_min);
         if (en < st) begin
            // window runs past midnight: the day bit belongs to the day it opened
            if (now_t < en) begin
               st  = st - int'(DAY_MINUTES);
               pos = (wd + 5) % int'(WEEK_DAYS);
            end else begin
               en  = en + int'(DAY_MINUTES);
               pos = (wd + 6) % int'(WEEK_DAYS);
            end
         end else begin
            pos = wd % int'(WEEK_DAYS);
         end
         if (e.day_mask[pos] && st <= now_t && now_t < en) begin
            hit             = 1'b1;
            on              = 1'b1;
            r.matched_index = 3'(i);
            if (it.cmd_on) begin
               c_en = 1'b0;
            end else if (c_en && st <= cmd_t && cmd_t < en) begin
               on = 1'b0;
            end
         end
      end

      if (!hit) begin
         if (!it.cmd_on) begin
            c_en = 1'b0;
         end else if (c_en) begin
            on = 1'b1;
         end
      end

      r.switch_on       = on;
      r.cmd_enable_next = c_en;
      r.window_matched  = hit;
      pending_verdicts.push_back(r);
   endfunction

   // ------------------------------------------------------------------------
   // Item builders
   // ------------------------------------------------------------------------

   function automatic logic [28:0] pack_entry(input int sh, input int sm, input int eh,
                                              input int em, input logic [6:0] days);
      entry_type e;
      e.start_hour = 5'(sh);
      e.start_min  = 6'(sm);
      e.end_hour   = 5'(eh);
      e.end_min    = 6'(em);
      e.day_mask   = days;
      return e;
   endfunction

   function automatic req_item_type load_item(input int idx, input logic [28:0] word);
      req_item_type it;
      it             = '0;
      it.kind        = KIND_LOAD;
      it.range_first = 4'(idx);
      it.entry_word  = word;
      return it;
   endfunction

   function automatic req_item_type check_item(input int first, input int last,
                                               input int hh, input int mm, input int wd,
                                               input bit c_on, input bit c_en,
                                               input int ch, input int cm);
      req_item_type it;
      it             = '0;
      it.kind        = KIND_CHECK;
      it.range_first = 4'(first);
      it.range_end   = 4'(last);
      it.now_hour    = 5'(hh);
      it.now_minute  = 6'(mm);
      it.weekday     = 8'(wd);
      it.cmd_on      = c_on;
      it.cmd_enable  = c_en;
      it.cmd_hour    = 5'(ch);
      it.cmd_minute  = 6'(cm);
      return it;
   endfunction

   // minutes of day (may be off by a day) to hour and minute
   function automatic void split_minutes(input int t, output logic [4:0] hh,
                                         output logic [5:0] mm);
      t  = ((t % int'(DAY_MINUTES)) + int'(DAY_MINUTES)) % int'(DAY_MINUTES);
      hh = 5'(t / int'(MIN_PER_HOUR));
      mm = 6'(t % int'(MIN_PER_HOUR));
   endfunction

   // Random item: all bits start as noise; most items are then reshaped into
   // sane loads or checks, and check times often land near stored window edges.
   function automatic req_item_type random_item();
      req_item_type it;
      logic [95:0]  noise;
      entry_type    e;
      int           pick, first, base;

      noise = {$urandom, $urandom, $urandom};
      it    = noise[$bits(req_item_type)-1:0];
      pick  = $urandom_range(0, 99);
      if (pick < 10) begin
         return it;
      end
      if (pick < 40) begin
         it.kind        = KIND_LOAD;
         it.range_first = 4'($urandom_range(0, ENTRY_COUNT - 1));
         if ($urandom_range(0, 9) == 0) begin
            it.entry_word = pack_entry(0, 0, 23, 59, WDAY_ALL[6:0]);
         end else begin
            it.entry_word = pack_entry($urandom_range(0, 23), $urandom_range(0, 59),
                                       $urandom_range(0, 23), $urandom_range(0, 59),
                                       7'($urandom));
         end
         return it;
      end

      it.kind        = KIND_CHECK;
      first          = $urandom_range(0, ENTRY_COUNT - 1);
      it.range_first = 4'(first);
      it.range_end   = 4'($urandom_range(ENTRY_COUNT, first + 1));
      it.weekday     = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(1, 7))
                                                   : 8'($urandom_range(0, 255));
      e = sched_model[$urandom_range(0, ENTRY_COUNT - 1)];
      if ($urandom_range(0, 1)) begin
         base = ($urandom_range(0, 1) ? int'(e.start_hour) : int'(e.end_hour))
                * int'(MIN_PER_HOUR);
         base = base + ($urandom_range(0, 1) ? int'(e.start_min) : int'(e.end_min));
         split_minutes(base + $urandom_range(0, 2) - 1, it.now_hour, it.now_minute);
      end else begin
         it.now_hour   = 5'($urandom_range(0, 23));
         it.now_minute = 6'($urandom_range(0, 59));
      end
      if ($urandom_range(0, 1)) begin
         base = int'(e.start_hour) * int'(MIN_PER_HOUR) + int'(e.start_min);
         split_minutes(base + $urandom_range(0, 2) - 1, it.cmd_hour, it.cmd_minute);
      end else begin
         it.cmd_hour   = 5'($urandom_range(0, 23));
         it.cmd_minute = 6'($urandom_range(0, 59));
      end
      return it;
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   function automatic int draw_wait();
      return idle_off ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   task automatic drive_req(input req_item_type it);
      req_ch.kind        <= it.kind;
      req_ch.range_first <= it.range_first;
      req_ch.range_end   <= it.range_end;
      req_ch.entry_word  <= it.entry_word;
      req_ch.now_hour    <= it.now_hour;
      req_ch.now_minute  <= it.now_minute;
      req_ch.weekday     <= it.weekday;
      req_ch.cmd_on      <= it.cmd_on;
      req_ch.cmd_enable  <= it.cmd_enable;
      req_ch.cmd_hour    <= it.cmd_hour;
      req_ch.cmd_minute  <= it.cmd_minute;
   endtask

   // Sends one item; returns in the time step of its accept edge with valid
   // still high, so a back-to-back item needs no second assignment.
   task automatic send_item(input req_item_type it);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      drive_req(it);
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predict_switch(it);
   endtask

   // Sender goes quiet until every predicted verdict is back, then lets the
   // block settle (a trailing load leaves nothing to wait for).
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fault_count++;
      end
   endfunction

   initial begin : result_checker
      int           stall;
      rsp_item_type want;

      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         if (pending_verdicts.size() == 0) begin
            $error("result item with no check outstanding");
            fault_count++;
         end else begin
            want = pending_verdicts.pop_front();
            check_field("switch_on", int'(want.switch_on), int'(rsp_ch.switch_on));
            check_field("cmd_enable_next", int'(want.cmd_enable_next),
                        int'(rsp_ch.cmd_enable_next));
            check_field("window_matched", int'(want.window_matched),
                        int'(rsp_ch.window_matched));
            check_field("matched_index", int'(want.matched_index),
                        int'(rsp_ch.matched_index));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Cleared table: nothing matches, only the remote override acts.
   task automatic test_empty_table();
      send_item(check_item(0, 8, 12, 0, 0, 1, 1, 12, 0));   // forced on
      send_item(check_item(0, 8, 0, 0, 1, 0, 1, 0, 0));     // enable dropped
   endtask

   // Load index limits and reduction of hours and minutes.
   task automatic test_load_reduction();
      send_item(load_item(8, pack_entry(0, 0, 23, 59, WDAY_ALL[6:0])));   // dropped
      send_item(load_item(15, pack_entry(0, 0, 23, 59, WDAY_ALL[6:0])));  // dropped
      // all ones: 31:63 reduces to 7:03 for both ends, an empty window
      send_item(load_item(7, {29{1'b1}}));
      send_item(check_item(0, 8, 7, 3, 127, 0, 0, 0, 0));
      send_item(load_item(0, pack_entry(8, 0, 17, 30, WDAY_ALL[6:0])));
      send_item(check_item(0, 8, 8, 0, 3, 0, 0, 0, 0));     // start edge, inclusive
      send_item(check_item(0, 8, 17, 30, 3, 0, 0, 0, 0));   // end edge, exclusive
   endtask

   // Window across midnight, with the day bit shifted on either side.
   task automatic test_window_wrap();
      send_item(load_item(1, pack_entry(22, 0, 2, 30, 7'b0101010)));
      send_item(check_item(1, 2, 23, 15, 255, 0, 0, 0, 0));  // before midnight, code out of range
      send_item(check_item(1, 2, 1, 0, 128, 0, 0, 0, 0));    // after midnight
      send_item(check_item(1, 2, 2, 30, 1, 0, 0, 0, 0));     // end edge
      send_item(check_item(1, 2, 22, 0, 6, 0, 0, 0, 0));     // start edge
   endtask

   // Remote override after a match and without one.
   task automatic test_override();
      send_item(check_item(0, 1, 9, 0, 2, 1, 1, 9, 0));     // on wanted: enable dropped
      send_item(check_item(0, 1, 9, 0, 2, 0, 1, 8, 30));    // command inside window: off
      send_item(check_item(0, 1, 9, 0, 2, 0, 1, 18, 0));    // command outside: stays on
      send_item(check_item(0, 1, 9, 0, 2, 0, 0, 8, 30));    // override inactive
      send_item(check_item(0, 1, 3, 0, 2, 1, 0, 3, 0));     // no match, override inactive
   endtask

   // Scan range limits, last table entry, raw out-of-range times.
   task automatic test_range_limits();
      send_item(load_item(7, pack_entry(0, 0, 23, 59, WDAY_ALL[6:0])));
      send_item(check_item(7, 15, 31, 63, 200, 0, 1, 31, 63));  // time past the day
      send_item(check_item(7, 15, 23, 58, 4, 0, 0, 0, 0));      // hit on last entry
      send_item(check_item(5, 3, 12, 0, 5, 1, 1, 12, 0));       // reversed range
      send_item(check_item(0, 0, 12, 0, 5, 0, 1, 12, 0));       // empty range
      send_item(check_item(2, 8, 12, 0, 5, 0, 1, 11, 0));       // skips empty entries
   endtask

   // Mostly well-formed traffic with noise, idle-free stretches, one drain.
   task automatic test_random_traffic();
      req_item_type it;
      int           sent;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         idle_off = (sent % 128) >= 100;
         it = random_item();
         send_item(it);
         // ignored loads do not count
         if (!(it.kind == KIND_LOAD && it.range_first >= ENTRY_COUNT)) begin
            sent++;
         end
         if (sent == RANDOM_ITEMS / 2) begin
            wait_drained();
            sent++;
         end
      end
      idle_off = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin : run_tests
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      drive_req('0);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_load_reduction();
      test_window_wrap();
      test_override();
      test_range_limits();
      wait_drained();
      test_random_traffic();
      wait_drained();

      if (fault_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("tb: failure");
      $finish;
   end

endmodule

FILE: weekly_time_window_matcher.f
hw/rtl/wtwm_pkg.sv
hw/rtl/wtwm_req_if.sv
hw/rtl/wtwm_rsp_if.sv
hw/rtl/wtwm_ctrl.sv
hw/rtl/wtwm_dpath.sv
hw/rtl/weekly_time_window_matcher.sv
test/testbench.sv
